// File: src/mcond_pkg.sv
// Shared types, widths and codes for the magnetometer sample conditioner.
// Used by mcond_lane, mcond_isqrt and magnetometer_sample_conditioner.
package mcond_pkg;

  localparam int RAW_W   = 16;  // raw axis reading
  localparam int FIELD_W = 21;  // scaled field, 1/32768 gauss
  localparam int RANGE_W = 5;   // range in gauss, 2 .. 20
  localparam int COEFF_W = 16;  // Q15 blend weight as written
  localparam int WEIGHT_W = 18; // signed operand width of a blend weight
  localparam int PROD_W  = 39;  // one blend product
  localparam int BLEND_W = 40;  // blend sum with rounding bias
  localparam int SQ_W    = 39;  // one squared axis
  localparam int SUM_W   = 41;  // sum of three squared axes
  localparam int ROOT_W  = 42;  // working width of the square root
  localparam int NORM_W  = 21;  // final norm
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 21;
  localparam int NUM_AXES   = 3;

  localparam logic [COEFF_W-1:0] Q15_ONE = 16'h8000;
  localparam logic [ROOT_W-1:0] ROOT_BIT_INIT = ROOT_W'(1) << (SUM_W - 1);
  localparam logic [BLEND_W-1:0] BLEND_HALF = BLEND_W'(16384);

  // Device status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BROKEN   = 2'd1;
  localparam logic [1:0] STAT_READ_ERR = 2'd2;

  // Request types.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_STATUS = 1'b1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_SELECT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEFF = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_MIN     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_MAX     = 4'd3;

  typedef struct packed {
    logic                start;
    logic [RANGE_W-1:0]  range;
    logic [COEFF_W-1:0]  coeff;
  } lane_ctrl_t;

  typedef struct packed {
    logic                      done;
    logic signed [FIELD_W-1:0] field;
    logic signed [FIELD_W-1:0] smooth;
    logic [SQ_W-1:0]           square;
  } lane_res_t;

  // Full-scale range in gauss: code times six plus two.
  function automatic logic [RANGE_W-1:0] range_gauss(input logic [1:0] sel);
    return RANGE_W'(sel) * RANGE_W'(6) + RANGE_W'(2);
  endfunction

  // Weights above one saturate to one.
  function automatic logic [COEFF_W-1:0] clamp_coeff(input logic [COEFF_W-1:0] c);
    return (c > Q15_ONE) ? Q15_ONE : c;
  endfunction

endpackage

// File: src/mcond_lane.sv
// One axis lane: scales the raw reading, blends it with the previous scaled
// reading and squares it. Depends on mcond_pkg.
module mcond_lane (
  input  logic                              clk,
  input  logic                              rst,
  input  mcond_pkg::lane_ctrl_t             ctrl,
  input  logic signed [mcond_pkg::RAW_W-1:0] raw,
  output mcond_pkg::lane_res_t              res
);
  import mcond_pkg::*;

  logic signed [FIELD_W-1:0] field_s1;
  logic signed [FIELD_W-1:0] prev;
  logic signed [PROD_W-1:0]  p_cur;
  logic signed [PROD_W-1:0]  p_prev;
  logic [SQ_W-1:0]           square;
  logic signed [FIELD_W-1:0] field_s2;
  logic signed [FIELD_W-1:0] smooth;
  logic                      v1;
  logic                      v2;
  logic                      done;

  logic signed [RANGE_W+RAW_W:0]   scaled;
  logic signed [WEIGHT_W-1:0]      w_cur;
  logic signed [WEIGHT_W-1:0]      w_prev;
  logic signed [2*FIELD_W-1:0]     sq_full;
  logic signed [BLEND_W-1:0]       blend_sum;
  logic signed [BLEND_W-1:0]       blend_shr;
  logic [COEFF_W-1:0]              c_sat;

  assign scaled  = raw * $signed({1'b0, ctrl.range});
  assign c_sat   = clamp_coeff(ctrl.coeff);
  assign w_cur   = $signed({2'b00, c_sat});
  assign w_prev  = $signed(WEIGHT_W'({1'b0, Q15_ONE}) - WEIGHT_W'(c_sat));
  assign sq_full = field_s1 * field_s1;
  // Floor shift after the half bias gives round to nearest, ties upward.
  assign blend_sum = BLEND_W'(p_cur) + BLEND_W'(p_prev) + BLEND_HALF;
  assign blend_shr = blend_sum >>> 15;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
      prev <= '0;
    end else begin
      v1   <= ctrl.start;
      v2   <= v1;
      done <= v2;
      if (v1) begin
        prev <= field_s1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      field_s1 <= scaled[FIELD_W-1:0];
    end
    if (v1) begin
      p_cur    <= PROD_W'(w_cur * field_s1);
      p_prev   <= PROD_W'(w_prev * prev);
      square   <= sq_full[SQ_W-1:0];
      field_s2 <= field_s1;
    end
    if (v2) begin
      smooth <= blend_shr[FIELD_W-1:0];
    end
  end

  assign res.done   = done;
  assign res.field  = field_s2;
  assign res.smooth = smooth;
  assign res.square = square;

endmodule

// File: src/mcond_isqrt.sv
// Bit-serial integer square root, one result bit per cycle, truncating.
// Depends on mcond_pkg.
module mcond_isqrt (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [mcond_pkg::SUM_W-1:0]      n,
  output logic                             done,
  output logic [mcond_pkg::NORM_W-1:0]     root
);
  import mcond_pkg::*;

  logic [SUM_W-1:0]  rem;
  logic [ROOT_W-1:0] acc;
  logic [ROOT_W-1:0] bitm;
  logic              busy;
  logic [ROOT_W-1:0] trial;
  logic              ge;

  assign trial = acc + bitm;
  assign ge    = ROOT_W'(rem) >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitm[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= n;
      acc  <= '0;
      bitm <= ROOT_BIT_INIT;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - trial[SUM_W-1:0];
        acc <= (acc >> 1) + bitm;
      end else begin
        acc <= acc >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

  assign root = acc[NORM_W-1:0];

endmodule

// File: src/magnetometer_sample_conditioner.sv
// Top level of the magnetometer sample conditioner: three axis lanes, the
// merging stage with the square root, status handling and the output register.
// Depends on mcond_pkg, mcond_lane and mcond_isqrt.

// One item is taken at a time. A status request, a sample while the status
// is not ok, or a sample with a bus error goes from its transfer straight to
// loading the output register and then back to idle. A good sample passes
// the axis lanes (scale, multiply, round), the square root of the summed
// squares (21 bit-serial iterations and the check of the window), the load
// of the output register and the return to idle. A finished result sits in
// the output register while the next item is accepted; an item only waits
// at its end, for as long as the output is stalled, if that register is
// still full.
module magnetometer_sample_conditioner (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [mcond_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mcond_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  req_type,
  input  logic signed [mcond_pkg::RAW_W-1:0]    raw_x,
  input  logic signed [mcond_pkg::RAW_W-1:0]    raw_y,
  input  logic signed [mcond_pkg::RAW_W-1:0]    raw_z,
  input  logic                                  bus_error,
  input  logic [1:0]                            override_status,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [1:0]                            status,
  output logic                                  updated,
  output logic signed [mcond_pkg::FIELD_W-1:0]  field_x,
  output logic signed [mcond_pkg::FIELD_W-1:0]  field_y,
  output logic signed [mcond_pkg::FIELD_W-1:0]  field_z,
  output logic signed [mcond_pkg::FIELD_W-1:0]  smooth_x,
  output logic signed [mcond_pkg::FIELD_W-1:0]  smooth_y,
  output logic signed [mcond_pkg::FIELD_W-1:0]  smooth_z,
  output logic [mcond_pkg::NORM_W-1:0]          field_norm
);
  import mcond_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LANES = 4'b0010,
    ST_ROOT  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [1:0]         range_select;
  logic [COEFF_W-1:0] filter_coeff;
  logic [NORM_W-1:0]  norm_min;
  logic [NORM_W-1:0]  norm_max;
  logic [1:0]         dev_status;

  logic [1:0]                res_status;
  logic                      res_updated;
  logic signed [FIELD_W-1:0] res_field [NUM_AXES];
  logic signed [FIELD_W-1:0] res_smooth [NUM_AXES];
  logic [NORM_W-1:0]         res_norm;

  logic                      in_xfer;
  logic                      sample_go;
  logic                      out_free;
  lane_ctrl_t                lane_ctrl;
  lane_res_t                 lane_res [NUM_AXES];
  logic signed [RAW_W-1:0]   lane_raw [NUM_AXES];
  logic [NUM_AXES-1:0]       lane_done;
  logic [SUM_W-1:0]          sq_sum;
  logic                      root_done;
  logic [NORM_W-1:0]         root;
  logic                      out_of_window;

  assign in_stall  = (state != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign sample_go = in_xfer && (req_type == REQ_SAMPLE) && (dev_status == STAT_OK)
                     && !bus_error;
  assign out_free  = !out_valid || !out_stall;

  assign lane_ctrl.start = sample_go;
  assign lane_ctrl.range = range_gauss(range_select);
  assign lane_ctrl.coeff = filter_coeff;

  assign lane_raw[0] = raw_x;
  assign lane_raw[1] = raw_y;
  assign lane_raw[2] = raw_z;

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
    mcond_lane u_lane (
      .clk  (clk),
      .rst  (rst),
      .ctrl (lane_ctrl),
      .raw  (lane_raw[i]),
      .res  (lane_res[i])
    );
    assign lane_done[i] = lane_res[i].done;
  end

  // Merge: sum the squared axes into the square root unit.
  assign sq_sum = SUM_W'(lane_res[0].square) + SUM_W'(lane_res[1].square)
                  + SUM_W'(lane_res[2].square);

  mcond_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_LANES && lane_done[0]),
    .n     (sq_sum),
    .done  (root_done),
    .root  (root)
  );

  assign out_of_window = (root > norm_max) || (root < norm_min);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (sample_go) begin
          state_next = ST_LANES;
        end else if (in_xfer) begin
          state_next = ST_DONE;
        end
      end
      ST_LANES: begin
        if (lane_done[0]) begin
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      range_select <= 2'd0;
      filter_coeff <= COEFF_W'(16384);
      norm_min     <= NORM_W'(6554);
      norm_max     <= NORM_W'(22938);
      dev_status   <= STAT_OK;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RANGE_SELECT: range_select <= cfg_data[1:0];
          REG_FILTER_COEFF: filter_coeff <= cfg_data[COEFF_W-1:0];
          REG_NORM_MIN:     norm_min     <= cfg_data[NORM_W-1:0];
          REG_NORM_MAX:     norm_max     <= cfg_data[NORM_W-1:0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        if (req_type == REQ_STATUS) begin
          if (override_status <= STAT_READ_ERR) begin
            dev_status <= override_status;
          end
        end else if (dev_status == STAT_OK && bus_error) begin
          dev_status <= STAT_BROKEN;
        end
      end
      if (state == ST_ROOT && root_done && out_of_window) begin
        dev_status <= STAT_READ_ERR;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result assembly; the payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_updated <= 1'b0;
      res_norm    <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        res_field[i]  <= '0;
        res_smooth[i] <= '0;
      end
      if (req_type == REQ_STATUS) begin
        res_status <= (override_status <= STAT_READ_ERR) ? override_status : dev_status;
      end else if (dev_status == STAT_OK && bus_error) begin
        res_status <= STAT_BROKEN;
      end else begin
        res_status <= dev_status;
      end
    end
    if (state == ST_LANES && lane_done[0]) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        res_field[i]  <= lane_res[i].field;
        res_smooth[i] <= lane_res[i].smooth;
      end
    end
    if (state == ST_ROOT && root_done) begin
      res_updated <= 1'b1;
      res_norm    <= root;
      res_status  <= out_of_window ? STAT_READ_ERR : dev_status;
    end
    if (state == ST_DONE && out_free) begin
      status     <= res_status;
      updated    <= res_updated;
      field_x    <= res_field[0];
      field_y    <= res_field[1];
      field_z    <= res_field[2];
      smooth_x   <= res_smooth[0];
      smooth_y   <= res_smooth[1];
      smooth_z   <= res_smooth[2];
      field_norm <= res_norm;
    end
  end

  // The lanes run in lockstep, so they must finish together.
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    (lane_done[0] == lane_done[1]) && (lane_done[0] == lane_done[2]))
    else $error("axis lanes out of step");

  a_root_in_state: assert property (@(posedge clk) disable iff (rst)
    root_done |-> (state == ST_ROOT))
    else $error("square root finished outside its state");

  a_no_update_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !updated) |-> (field_norm == '0 && field_x == '0 && smooth_z == '0))
    else $error("result without new values carries nonzero fields");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= STAT_READ_ERR))
    else $error("unknown status code on output");

endmodule
